// ===== design/tsfs_pkg.sv =====
// shared constants, register codes and types for the segment framer / scrambler
// no dependencies; imported by tsfs_crc8, the top level and the testbench

package tsfs_pkg;

	// buffer and frame geometry
	localparam int BUFFER_DEPTH  = 32768;
	localparam int SEGMENT_LEN   = 188;
	localparam int HEADER_LEN    = 8;
	localparam int MAX_FRAME_LEN = 16384;

	localparam int ADDR_W = $clog2(BUFFER_DEPTH);
	localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);
	localparam int REM_W  = (SEGMENT_LEN > 1) ? $clog2(SEGMENT_LEN) : 1;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 15;
	localparam int FLEN_W     = 15;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_LEN   = 2'd0,
		REG_BYTE_OUTPUT = 2'd1,
		REG_CRC_POLY    = 2'd2
	} cfg_reg_t;

	// frame length in use and bit position inside a frame
	localparam int MIN_FRAME_LEN = HEADER_LEN + SEGMENT_LEN;
	localparam int EFF_W         = $clog2(MAX_FRAME_LEN + 1);
	localparam int POS_W         = EFF_W + 3;
	localparam int BIDX_W        = POS_W - 3;
	localparam int PLEN_W        = $clog2(MAX_FRAME_LEN);
	localparam int MAXSEG_W      = $clog2((MAX_FRAME_LEN - HEADER_LEN) / SEGMENT_LEN + 1);

	// reciprocal for the segment count of a frame length
	localparam int SEG_SHIFT = $clog2(MAX_FRAME_LEN) + $clog2(SEGMENT_LEN) + 1;
	localparam int SEG_RECIP = ((1 << SEG_SHIFT) + SEGMENT_LEN - 1) / SEGMENT_LEN;
	localparam int RECIP_W   = SEG_SHIFT - $clog2(SEGMENT_LEN) + 1;

	// reset values
	localparam int           FRAME_LEN_RESET = 1024;
	localparam int           MAXSEG_RESET    = (FRAME_LEN_RESET - HEADER_LEN) / SEGMENT_LEN;
	localparam logic [7:0]   CRC_POLY_RESET  = 8'h07;

	// header marks and scrambler
	localparam logic [7:0]   MARK_FULL    = 8'h55;
	localparam logic [7:0]   MARK_PARTIAL = 8'hAA;
	localparam int           LFSR_W       = 16;
	localparam logic [15:0]  LFSR_SEED    = 16'hACE1;

	// length field covered by the header check byte
	localparam int LEN_FIELD_BYTES = 4;

	typedef struct packed {
		logic                         start;
		logic [7:0]                   poly;
		logic [8*LEN_FIELD_BYTES-1:0] data;
	} crc_req_t;

endpackage

// ===== design/tsfs_ifs.sv =====
// valid/ready channel interfaces for the request and result words
// no dependencies

interface tsfs_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] data_byte;
	logic       message_start;

	modport source(output valid, output req_type, output data_byte, output message_start,
		input ready);
	modport sink(input valid, input req_type, input data_byte, input message_start,
		output ready);
endinterface

interface tsfs_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_value;
	logic       frame_last;

	modport source(output valid, output out_value, output frame_last, input ready);
	modport sink(input valid, input out_value, input frame_last, output ready);
endinterface

// ===== design/tsfs_ram.sv =====
// simple dual-port ram: one write port, one read port with registered data
// no dependencies

module tsfs_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== design/tsfs_crc8.sv =====
// header check byte: msb-first crc-8 over the length field, one byte per cycle
// depends on tsfs_pkg

module tsfs_crc8
	import tsfs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  crc_req_t   req,
	output logic [7:0] crc
);

	localparam int STEP_W = $clog2(LEN_FIELD_BYTES + 1);

	logic [STEP_W-1:0]            left_q;
	logic [7:0]                   crc_q;
	logic [7:0]                   poly_q;
	logic [8*LEN_FIELD_BYTES-1:0] data_q;

	function automatic logic [7:0] crc_byte(input logic [7:0] c_in, input logic [7:0] d,
		input logic [7:0] poly);
		logic [7:0] c;
		c = c_in ^ d;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ((c << 1) ^ poly) : (c << 1);
		end
		return c;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			crc_q  <= '0;
		end else if (req.start) begin
			left_q <= STEP_W'(LEN_FIELD_BYTES);
			crc_q  <= '0;
		end else if (left_q != '0) begin
			left_q <= left_q - 1'b1;
			crc_q  <= crc_byte(crc_q, data_q[7:0], poly_q);
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			data_q <= req.data;
			poly_q <= req.poly;
		end else if (left_q != '0) begin
			data_q <= data_q >> 8;
		end
	end

	assign crc = crc_q;

endmodule

// ===== design/ts_segment_framer_scrambler.sv =====
// top level of the segment framer with lfsr16 scrambler
// depends on tsfs_pkg, tsfs_ifs, tsfs_ram, tsfs_crc8
//
// usage
//   req carries push words (req_type 0: data_byte into the payload fifo) and pull words
//   (req_type 1: emit the next frame element). every pull gives exactly one word on res,
//   a push gives none. a frame is an 8-byte header, whole segments of payload, then zero
//   padding, all xored with a 16-bit lfsr reseeded at each frame start.
//   cfg_we / cfg_index / cfg_data write frame length, byte/bit mode and crc polynomial.
// timing
//   one word per clock on req while the skid entry is empty; a pull's result is registered
//   into the res register, or into the skid entry while a result waits. the limit is the
//   combinational frame element path fed by a two-byte look-ahead window in front of the
//   fifo ram read port. the header check byte is worked out one length byte at a time
//   from frame start, before the header reaches it.
// reset
//   arst_n clears the fifo pointers and fill count, the frame position and the scrambler;
//   the fifo ram itself is not cleared, so there is no clearing pass and req is ready
//   in the first cycle after reset.
// stall
//   res has an output register plus one skid entry: pushes and pulls keep flowing while
//   a result waits, and req.ready drops only once the skid entry is filled.

module ts_segment_framer_scrambler
	import tsfs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	tsfs_req_if.sink              req,
	tsfs_res_if.source            res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int PROD_W = EFF_W + RECIP_W;

	// configuration
	logic [EFF_W-1:0]    eff_q;       // saturated frame length
	logic [MAXSEG_W-1:0] maxseg_q;    // segments that fit in a frame
	logic                byte_mode_q;
	logic [7:0]          poly_q;

	// fifo control
	logic [ADDR_W-1:0] head_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  segbytes_q;    // count rounded down to whole segments
	logic [REM_W-1:0]  rem_q;         // count modulo segment length
	logic              drop_q;

	// look-ahead window: byte at head and byte after it
	logic [7:0] w0_q;
	logic [7:0] w1_q;
	logic       sel_q;                // w1 comes from the ram read this cycle
	logic [7:0] rd_data;

	// frame state
	logic [POS_W-1:0]  pos_q;
	logic [PLEN_W-1:0] plen_q;
	logic              mark_q;
	logic [15:0]       lfsr_q;
	logic [7:0]        crc_byte;

	// result register and skid entry
	logic       out_v_q;
	logic [7:0] out_val_q;
	logic       out_last_q;
	logic       skid_v_q;
	logic [7:0] skid_val_q;
	logic       skid_last_q;

	// combinational
	logic              push_acc;
	logic              pull_acc;
	logic              taken;
	logic              full;
	logic              drop_d;
	logic              wr;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;
	logic              hd_adv;
	logic              cnt_inc;
	logic              cnt_dec;
	logic [7:0]        w1_cur;
	logic [7:0]        w0_d;
	logic [7:0]        w1_d;

	logic              start;
	logic [PLEN_W-1:0] maxp;
	logic              seg_full;
	logic [PLEN_W-1:0] plen_new;
	logic [PLEN_W-1:0] plen_cur;
	logic              mark_cur;
	logic [31:0]       plen32;
	logic [2:0]        off;
	logic [BIDX_W:0]   b0;
	logic [BIDX_W:0]   b1;
	logic [BIDX_W:0]   pay_lim;
	logic              hdr0, hdr1, pay0, pay1;
	logic              adv;
	logic [7:0]        byte0, byte1;
	logic [15:0]       window;
	logic [15:0]       lfsr_cur;
	logic [7:0]        new_val;
	logic              new_last;
	logic [POS_W:0]    pos_sum;
	logic [POS_W:0]    total_bits;
	logic [POS_W-1:0]  pos_d;

	crc_req_t          crc_req;

	// config write decode
	logic [31:0]        flen32;
	logic [EFF_W-1:0]   eff_new;
	logic [EFF_W-1:0]   eff_net;
	logic [PROD_W-1:0]  seg_prod;

	function automatic logic [ADDR_W-1:0] fifo_wrap(input logic [ADDR_W:0] sum);
		logic [ADDR_W:0] s;
		s = sum;
		if (s >= (ADDR_W+1)'(BUFFER_DEPTH)) begin
			s = s - (ADDR_W+1)'(BUFFER_DEPTH);
		end
		return s[ADDR_W-1:0];
	endfunction

	function automatic logic [7:0] hdr_byte(input logic [2:0] idx, input logic mark_full,
		input logic [31:0] len, input logic [7:0] chk);
		logic [7:0] v;
		unique case (idx)
			3'd0, 3'd1, 3'd2: v = mark_full ? MARK_FULL : MARK_PARTIAL;
			3'd3:             v = len[7:0];
			3'd4:             v = len[15:8];
			3'd5:             v = len[23:16];
			3'd6:             v = len[31:24];
			3'd7:             v = chk;
		endcase
		return v;
	endfunction

	// fibonacci lfsr, taps 0,2,3,5, shifting right; one or eight steps
	function automatic logic [15:0] lfsr_run(input logic [15:0] s, input logic eight);
		logic [15:0] v;
		v = s;
		for (int k = 0; k < 8; k++) begin
			if (eight || k == 0) begin
				v = {v[0] ^ v[2] ^ v[3] ^ v[5], v[15:1]};
			end
		end
		return v;
	endfunction

	// ---------------------------------------------------------------- handshake
	assign req.ready = !skid_v_q;
	assign push_acc  = req.valid && req.ready && !req.req_type;
	assign pull_acc  = req.valid && req.ready && req.req_type;
	assign taken     = out_v_q && res.ready;

	// ---------------------------------------------------------------- config
	// segment count is taken from the written value, so a pull right after the
	// write already sees it
	always_comb begin
		flen32 = 32'(cfg_data);
		if (flen32 < 32'(MIN_FRAME_LEN)) begin
			eff_new = EFF_W'(MIN_FRAME_LEN);
		end else if (flen32 > 32'(MAX_FRAME_LEN)) begin
			eff_new = EFF_W'(MAX_FRAME_LEN);
		end else begin
			eff_new = EFF_W'(flen32);
		end
		eff_net  = eff_new - EFF_W'(HEADER_LEN);
		seg_prod = PROD_W'(eff_net) * PROD_W'(SEG_RECIP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_q       <= EFF_W'(FRAME_LEN_RESET);
			maxseg_q    <= MAXSEG_W'(MAXSEG_RESET);
			byte_mode_q <= 1'b1;
			poly_q      <= CRC_POLY_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_LEN: begin
					eff_q    <= eff_new;
					maxseg_q <= MAXSEG_W'(seg_prod >> SEG_SHIFT);
				end
				REG_BYTE_OUTPUT: byte_mode_q <= cfg_data[0];
				REG_CRC_POLY:    poly_q      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- frame element
	always_comb begin
		start    = (pos_q == '0);
		maxp     = PLEN_W'(maxseg_q * SEGMENT_LEN);
		seg_full = (segbytes_q >= CNT_W'(maxp));
		plen_new = seg_full ? maxp : PLEN_W'(segbytes_q);
		plen_cur = start ? plen_new : plen_q;
		mark_cur = start ? seg_full : mark_q;
		plen32   = 32'(plen_cur);

		// an element covers at most two frame bytes
		off     = pos_q[2:0];
		b0      = (BIDX_W+1)'(pos_q[POS_W-1:3]);
		b1      = b0 + 1'b1;
		pay_lim = (BIDX_W+1)'(HEADER_LEN) + (BIDX_W+1)'(plen_cur);
		hdr0    = (b0 < (BIDX_W+1)'(HEADER_LEN));
		hdr1    = (b1 < (BIDX_W+1)'(HEADER_LEN));
		pay0    = !hdr0 && (b0 < pay_lim);
		pay1    = !hdr1 && (b1 < pay_lim);

		w1_cur = sel_q ? rd_data : w1_q;

		// a payload byte leaves the fifo with its last bit
		adv = pay0 && (byte_mode_q || off == 3'd7) && (count_q != '0);

		if (hdr0) begin
			byte0 = hdr_byte(b0[2:0], mark_cur, plen32, crc_byte);
		end else if (pay0) begin
			byte0 = w0_q;
		end else begin
			byte0 = 8'h00;
		end
		if (hdr1) begin
			byte1 = hdr_byte(b1[2:0], mark_cur, plen32, crc_byte);
		end else if (pay1) begin
			byte1 = adv ? w1_cur : w0_q;
		end else begin
			byte1 = 8'h00;
		end
		window = {byte1, byte0} >> off;

		lfsr_cur = start ? LFSR_SEED : lfsr_q;
		if (byte_mode_q) begin
			new_val = window[7:0] ^ lfsr_cur[7:0];
		end else begin
			new_val = {7'b0, window[0] ^ lfsr_cur[0]};
		end

		pos_sum    = {1'b0, pos_q} + (byte_mode_q ? (POS_W+1)'(8) : (POS_W+1)'(1));
		total_bits = (POS_W+1)'({eff_q, 3'b000});
		new_last   = (pos_sum >= total_bits);
		pos_d      = new_last ? '0 : pos_sum[POS_W-1:0];
	end

	assign crc_req.start = pull_acc && start;
	assign crc_req.poly  = poly_q;
	assign crc_req.data  = (8*LEN_FIELD_BYTES)'(plen_new);

	tsfs_crc8 u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (crc_req),
		.crc    (crc_byte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			plen_q <= '0;
			mark_q <= 1'b0;
			lfsr_q <= LFSR_SEED;
		end else if (pull_acc) begin
			pos_q  <= pos_d;
			lfsr_q <= lfsr_run(lfsr_cur, byte_mode_q);
			if (start) begin
				plen_q <= plen_new;
				mark_q <= seg_full;
			end
		end
	end

	// ---------------------------------------------------------------- fifo
	always_comb begin
		full    = (count_q == CNT_W'(BUFFER_DEPTH));
		drop_d  = req.message_start ? full : drop_q;
		wr      = push_acc && !drop_d;
		// a full fifo overwrites its oldest byte
		waddr   = full ? head_q : fifo_wrap((ADDR_W+1)'(head_q) + (ADDR_W+1)'(count_q));
		hd_adv  = (wr && full) || (pull_acc && adv);
		cnt_inc = wr && !full;
		cnt_dec = pull_acc && adv;
		raddr   = fifo_wrap((ADDR_W+1)'(head_q) + (ADDR_W+1)'(2));

		if (hd_adv) begin
			w0_d = w1_cur;
			w1_d = w1_q;
		end else begin
			w0_d = (wr && (full || count_q == '0)) ? req.data_byte : w0_q;
			w1_d = (wr && !full && count_q == CNT_W'(1)) ? req.data_byte : w1_cur;
		end
	end

	tsfs_ram #(
		.DEPTH (BUFFER_DEPTH),
		.WIDTH (8)
	) u_ram (
		.clk   (clk),
		.we    (wr),
		.waddr (waddr),
		.wdata (req.data_byte),
		.raddr (raddr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			count_q    <= '0;
			segbytes_q <= '0;
			rem_q      <= '0;
			drop_q     <= 1'b0;
			sel_q      <= 1'b0;
		end else begin
			sel_q <= hd_adv;
			if (push_acc) begin
				drop_q <= drop_d;
			end
			if (hd_adv) begin
				head_q <= fifo_wrap((ADDR_W+1)'(head_q) + (ADDR_W+1)'(1));
			end
			if (cnt_inc) begin
				count_q <= count_q + 1'b1;
				if (rem_q == REM_W'(SEGMENT_LEN - 1)) begin
					rem_q      <= '0;
					segbytes_q <= segbytes_q + CNT_W'(SEGMENT_LEN);
				end else begin
					rem_q <= rem_q + 1'b1;
				end
			end else if (cnt_dec) begin
				count_q <= count_q - 1'b1;
				if (rem_q == '0) begin
					rem_q      <= REM_W'(SEGMENT_LEN - 1);
					segbytes_q <= segbytes_q - CNT_W'(SEGMENT_LEN);
				end else begin
					rem_q <= rem_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		w0_q <= w0_d;
		w1_q <= w1_d;
	end

	// ---------------------------------------------------------------- result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (taken) begin
				skid_v_q <= 1'b0;
			end
		end else if (pull_acc) begin
			if (!out_v_q || taken) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (taken) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q && taken) begin
			out_val_q  <= skid_val_q;
			out_last_q <= skid_last_q;
		end else if (pull_acc && (!out_v_q || taken)) begin
			out_val_q  <= new_val;
			out_last_q <= new_last;
		end
		if (pull_acc && out_v_q && !taken) begin
			skid_val_q  <= new_val;
			skid_last_q <= new_last;
		end
	end

	assign res.valid      = out_v_q;
	assign res.out_value  = out_val_q;
	assign res.frame_last = out_last_q;

	// ---------------------------------------------------------------- checks
	// skid entry only fills behind a waiting result
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry valid without a result in the output register");

	// segment split of the fill count stays consistent
	a_seg_split: assert property (@(posedge clk) disable iff (!arst_n)
		(segbytes_q + CNT_W'(rem_q)) == count_q)
		else $error("segment bytes plus remainder differ from fifo count");

	// fill count never passes the buffer depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(BUFFER_DEPTH))
		else $error("fifo count beyond buffer depth");

endmodule

// ===== sim/tb_ts_segment_framer_scrambler.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the segment framer / lfsr16 scrambler
// depends on tsfs_pkg, tsfs_ifs and the design top; predicts every frame word in place

module tb_ts_segment_framer_scrambler;
	import tsfs_pkg::*;

	localparam int CLK_PERIOD    = 8;
	localparam int RESET_CYCLES  = 9;
	// settle time after the last result; the header crc keeps running after the pull that starts a frame
	localparam int SETTLE_CYCLES = 8;
	// long receiver hold-off, well past the output register plus skid entry
	localparam int HOLD_CYCLES   = 300;
	// ~1300 words plus one long hold-off: many times over
	localparam int CYCLE_LIMIT   = 100000;
	localparam int unsigned POS_MASK = (1 << POS_W) - 1;

	typedef enum logic {
		REQ_PUSH = 1'b0,
		REQ_PULL = 1'b1
	} req_kind_t;

	typedef enum int {
		RX_FREE,
		RX_RANDOM,
		RX_ALTERNATE
	} rx_mode_t;

	typedef struct packed {
		req_kind_t  kind;
		logic [7:0] data;
		logic       msg_start;
	} req_word_t;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} elem_t;

	typedef struct packed {
		req_word_t word;
		logic      typed;
		elem_t     want;
	} dir_row_t;

	logic          clk = 1'b0;
	logic          arst_n;
	logic          cfg_we;
	cfg_reg_t      cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	tsfs_req_if req_ch();
	tsfs_res_if res_ch();

	ts_segment_framer_scrambler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	int cycle_count = 0;
	int errors      = 0;
	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("status: fail");
		$finish;
	end

	// ------------------------------------------------------------------
	// framer predictor: own copy of the payload fifo, frame state and settings
	// ------------------------------------------------------------------
	logic [7:0]    buf_mem [BUFFER_DEPTH];
	int unsigned   buf_rd;
	int unsigned   buf_fill;
	bit            discard_msg;
	int unsigned   bit_pos;          // frame position in bits
	int unsigned   pay_len;          // payload bytes reserved for this frame
	logic [63:0]   hdr_word;         // header byte 0 in bits 7:0
	logic [15:0]   scr_state;
	logic [FLEN_W-1:0] set_flen;
	bit            set_bytes;
	logic [7:0]    set_poly;

	// frame words still owed by the block, oldest first
	elem_t due_elems[$];

	bit hold_asked = 1'b0;
	int burst_left = 0;

	// frame length register clamped into the usable range
	function automatic int unsigned frame_len_used();
		int unsigned f;
		f = set_flen;
		if (f < MIN_FRAME_LEN)
			f = MIN_FRAME_LEN;
		if (f > MAX_FRAME_LEN)
			f = MAX_FRAME_LEN;
		return f;
	endfunction

	// msb-first crc-8 over the little-endian length field, zero start value
	function automatic logic [7:0] len_crc(logic [31:0] len, logic [7:0] poly);
		logic [7:0] c;
		int i;
		int k;
		c = '0;
		for (i = 0; i < LEN_FIELD_BYTES; i++) begin
			c ^= len[8*i +: 8];
			for (k = 0; k < 8; k++)
				c = c[7] ? ((c << 1) ^ poly) : (c << 1);
		end
		return c;
	endfunction

	// reserve whole segments, build the header and reseed the scrambler
	task automatic open_frame();
		int unsigned maxp;
		int unsigned avail;
		logic [7:0]  mark;
		logic [31:0] len32;
		maxp = ((frame_len_used() - HEADER_LEN) / SEGMENT_LEN) * SEGMENT_LEN;
		avail = (buf_fill < maxp) ? buf_fill : maxp;
		pay_len = (avail / SEGMENT_LEN) * SEGMENT_LEN;
		mark = (pay_len == maxp) ? MARK_FULL : MARK_PARTIAL;
		len32 = pay_len;
		hdr_word = {len_crc(len32, set_poly), len32, mark, mark, mark};
		scr_state = LFSR_SEED;
	endtask

	// one frame bit xored with the scrambler; payload bytes leave on their last bit
	function automatic logic scrambled_bit();
		int unsigned byte_idx;
		int unsigned bit_idx;
		logic d;
		logic fb;
		byte_idx = bit_pos >> 3;
		bit_idx = bit_pos & 7;
		d = 1'b0;
		if (byte_idx < HEADER_LEN) begin
			d = hdr_word[8*byte_idx + bit_idx];
		end else if (byte_idx - HEADER_LEN < pay_len) begin
			d = buf_mem[buf_rd][bit_idx];
			if (bit_idx == 7 && buf_fill > 0) begin
				buf_rd = (buf_rd + 1) % BUFFER_DEPTH;
				buf_fill--;
			end
		end
		d ^= scr_state[0];
		fb = scr_state[0] ^ scr_state[2] ^ scr_state[3] ^ scr_state[5];
		scr_state = {fb, scr_state[15:1]};
		bit_pos = (bit_pos + 1) & POS_MASK;
		return d;
	endfunction

	// apply one accepted request word; a pull queues the frame word it owes
	task automatic framer_step(input req_word_t w);
		int unsigned start;
		int unsigned total;
		int unsigned n;
		int k;
		elem_t e;
		if (w.kind == REQ_PUSH) begin
			// a new message into a full fifo is thrown away up to the next start
			if (w.msg_start)
				discard_msg = (buf_fill >= BUFFER_DEPTH);
			if (discard_msg)
				return;
			if (buf_fill >= BUFFER_DEPTH) begin
				// overflow inside a message: the oldest byte goes
				buf_mem[buf_rd] = w.data;
				buf_rd = (buf_rd + 1) % BUFFER_DEPTH;
			end else begin
				buf_mem[(buf_rd + buf_fill) % BUFFER_DEPTH] = w.data;
				buf_fill++;
			end
		end else begin
			if (bit_pos == 0)
				open_frame();
			total = frame_len_used() * 8;
			n = set_bytes ? 8 : 1;
			start = bit_pos;
			e.value = '0;
			for (k = 0; k < n; k++)
				e.value[k] = scrambled_bit();
			// position already past a shortened frame also closes it
			e.last = (start + n >= total);
			if (e.last)
				bit_pos = 0;
			due_elems = {due_elems, e};
		end
	endtask

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h", cycle_count, what, got, want);
		errors++;
	endtask

	// ------------------------------------------------------------------
	// request side: bursts of words with random gaps
	// ------------------------------------------------------------------
	task automatic offer(input req_word_t w);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(99) < 30) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		req_ch.valid         <= 1'b1;
		req_ch.req_type      <= w.kind;
		req_ch.data_byte     <= w.data;
		req_ch.message_start <= w.msg_start;
		do
			@(posedge clk);
		while (!req_ch.ready);
		framer_step(w);
	endtask

	// pulls carry random junk in the ignored fields
	function automatic req_word_t any_pull();
		req_word_t w;
		w.kind = REQ_PULL;
		w.data = 8'($urandom);
		w.msg_start = 1'($urandom);
		return w;
	endfunction

	task automatic push_byte(logic [7:0] data, logic msg_start);
		req_word_t w;
		w.kind = REQ_PUSH;
		w.data = data;
		w.msg_start = msg_start;
		offer(w);
	endtask

	task automatic pull_to_frame_end();
		do
			offer(any_pull());
		while (bit_pos != 0);
	endtask

	// stop offering until every owed word has come back, then let the block settle
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (due_elems.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// all three registers, back to back; unused upper data bits carry junk
	task automatic write_settings(logic [14:0] flen, bit bytes_mode, logic [7:0] poly);
		logic [CFG_DATA_W-1:0] mode_word;
		logic [CFG_DATA_W-1:0] poly_word;
		mode_word = {14'($urandom), bytes_mode};
		poly_word = {7'($urandom), poly};
		cfg_we    <= 1'b1;
		cfg_index <= REG_FRAME_LEN;
		cfg_data  <= flen;
		@(posedge clk);
		cfg_index <= REG_BYTE_OUTPUT;
		cfg_data  <= mode_word;
		@(posedge clk);
		cfg_index <= REG_CRC_POLY;
		cfg_data  <= poly_word;
		@(posedge clk);
		cfg_we <= 1'b0;
		set_flen  = flen;
		set_bytes = mode_word[0];
		set_poly  = poly_word[7:0];
	endtask

	// well-formed messages and pull runs, with a few messages missing their start mark
	task automatic run_traffic(int items, int push_pct, int pull_max);
		int done;
		int len;
		int i;
		bit broken;
		done = 0;
		while (done < items) begin
			if ($urandom_range(99) < push_pct) begin
				len = $urandom_range(1, 64);
				broken = ($urandom_range(99) < 8);
				for (i = 0; i < len; i++)
					push_byte(8'($urandom), (i == 0) && !broken);
			end else begin
				len = $urandom_range(1, pull_max);
				for (i = 0; i < len; i++)
					offer(any_pull());
			end
			done += len;
		end
	endtask

	task automatic run_phase(bit hold_first, logic [14:0] flen, bit bytes_mode, logic [7:0] poly,
		int items, int push_pct, int pull_max, bit to_frame_end);
		int i;
		write_settings(flen, bytes_mode, poly);
		if (hold_first) begin
			// receiver goes quiet while pulls keep coming, so req.ready must drop
			hold_asked = 1'b1;
			for (i = 0; i < 60; i++)
				offer(any_pull());
		end
		run_traffic(items, push_pct, pull_max);
		if (to_frame_end)
			pull_to_frame_end();
		wait_drained();
	endtask

	// ------------------------------------------------------------------
	// result side: stall pattern, long hold-off on request, in-order check
	// ------------------------------------------------------------------
	initial begin
		int       rx_left;
		int       hold_left;
		rx_mode_t rx_mode;
		logic     rdy;
		elem_t    got;
		elem_t    want;
		res_ch.ready = 1'b0;
		rx_left = 0;
		hold_left = 0;
		rx_mode = RX_FREE;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				got.value = res_ch.out_value;
				got.last  = res_ch.frame_last;
				if (due_elems.size() == 0) begin
					report_mismatch("word with nothing owed, out_value", got.value, 0);
				end else begin
					want = due_elems[0];
					due_elems.delete(0);
					if (got.value !== want.value)
						report_mismatch("out_value", got.value, want.value);
					if (got.last !== want.last)
						report_mismatch("frame_last", got.last, want.last);
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (hold_asked) begin
				hold_asked = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				rdy = 1'b0;
			end else begin
				if (rx_left == 0) begin
					rx_mode = rx_mode_t'($urandom_range(0, 2));
					rx_left = $urandom_range(16, 200);
				end
				rx_left--;
				case (rx_mode)
					RX_FREE: begin
						rdy = 1'b1;
					end
					RX_RANDOM: begin
						rdy = ($urandom_range(99) >= 30);
					end
					default: begin
						rdy = rx_left[0];
					end
				endcase
			end
			res_ch.ready <= rdy;
		end
	end

	// ------------------------------------------------------------------
	// directed words right after reset, default settings
	// the first two header bytes are 0xaa (empty fifo, partial frame) xored with
	// the seed's low and high byte, so they are known without the predictor
	// ------------------------------------------------------------------
	dir_row_t dir_rows [16] = '{
		'{'{REQ_PULL, 8'h00, 1'b0}, 1'b1, '{8'h4B, 1'b0}},
		'{'{REQ_PULL, 8'hFF, 1'b1}, 1'b1, '{8'h06, 1'b0}},
		'{'{REQ_PUSH, 8'h00, 1'b1}, 1'b0, '{8'h00, 1'b0}},
		'{'{REQ_PUSH, 8'hFF, 1'b0}, 1'b0, '{8'h00, 1'b0}},
		'{'{REQ_PUSH, 8'h80, 1'b0}, 1'b0, '{8'h00, 1'b0}},
		'{'{REQ_PUSH, 8'h01, 1'b0}, 1'b0, '{8'h00, 1'b0}},
		'{'{REQ_PUSH, 8'h7F, 1'b1}, 1'b0, '{8'h00, 1'b0}},
		'{'{REQ_PUSH, 8'hA5, 1'b0}, 1'b0, '{8'h00, 1'b0}},
		'{'{REQ_PULL, 8'h5A, 1'b0}, 1'b0, '{8'h00, 1'b0}},
		'{'{REQ_PULL, 8'h00, 1'b1}, 1'b0, '{8'h00, 1'b0}},
		'{'{REQ_PULL, 8'hFF, 1'b0}, 1'b0, '{8'h00, 1'b0}},
		'{'{REQ_PULL, 8'h00, 1'b0}, 1'b0, '{8'h00, 1'b0}},
		'{'{REQ_PULL, 8'h00, 1'b0}, 1'b0, '{8'h00, 1'b0}},
		'{'{REQ_PULL, 8'h00, 1'b0}, 1'b0, '{8'h00, 1'b0}},
		'{'{REQ_PULL, 8'h00, 1'b0}, 1'b0, '{8'h00, 1'b0}},
		'{'{REQ_PULL, 8'h00, 1'b0}, 1'b0, '{8'h00, 1'b0}}
	};

	initial begin
		int i;
		arst_n               = 1'b0;
		req_ch.valid         = 1'b0;
		req_ch.req_type      = REQ_PUSH;
		req_ch.data_byte     = '0;
		req_ch.message_start = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = REG_FRAME_LEN;
		cfg_data             = '0;

		// predictor starts from the reset state
		buf_rd      = 0;
		buf_fill    = 0;
		discard_msg = 1'b0;
		bit_pos     = 0;
		pay_len     = 0;
		hdr_word    = '0;
		scr_state   = LFSR_SEED;
		set_flen    = FRAME_LEN_RESET;
		set_bytes   = 1'b1;
		set_poly    = CRC_POLY_RESET;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < 16; i++) begin
			offer(dir_rows[i].word);
			if (dir_rows[i].typed)
				due_elems[due_elems.size() - 1] = dir_rows[i].want;
		end
		wait_drained();

		// shortest frame, zero polynomial, long receiver hold-off up front
		run_phase(1'b1, 15'd196, 1'b1, 8'h00, 100, 55, 48, 1'b0);
		// zero length clamps up to header plus one segment; all-ones polynomial
		run_phase(1'b0, 15'd0, 1'b1, 8'hFF, 100, 50, 64, 1'b0);
		// bit mode, left mid-byte so the next byte-mode phase starts unaligned
		run_phase(1'b0, 15'd300, 1'b0, 8'h07, 180, 40, 64, 1'b0);
		// all-ones length clamps to the largest frame; mostly pulls to go deep
		run_phase(1'b0, 15'h7FFF, 1'b1, 8'h31, 250, 20, 100, 1'b0);
		// frame shrinks under the current position: next pull closes it at once
		run_phase(1'b0, 15'd195, 1'b1, 8'($urandom), 80, 10, 60, 1'b1);
		run_phase(1'b0, 15'($urandom), 1'b1, 8'($urandom), 100, 50, 64, 1'b0);
		run_phase(1'b0, 15'($urandom_range(196, 2048)), 1'b1, 8'($urandom), 100, 60, 64, 1'b0);
		run_phase(1'b0, 15'd197, 1'b0, 8'($urandom), 100, 30, 64, 1'b0);

		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== files.f =====
design/tsfs_pkg.sv
design/tsfs_ifs.sv
design/tsfs_ram.sv
design/tsfs_crc8.sv
design/ts_segment_framer_scrambler.sv
sim/tb_ts_segment_framer_scrambler.sv
